/* sv/mhfp_pkg.sv */
// shared types and constants for the magic header frame parser
// no dependencies
`default_nettype none

package mhfp_pkg;

  localparam int unsigned WinDepth = 12;
  localparam int unsigned PtrW     = 4;
  localparam int unsigned ByteW    = 8;

  localparam logic [ByteW-1:0] MagicA     = 8'h0B;
  localparam logic [ByteW-1:0] MagicB     = 8'hB0;
  localparam logic [ByteW-1:0] MagicC     = 8'h21;
  localparam logic [ByteW-1:0] ParitySeed = 8'hDC;

  typedef enum logic [1:0] {
    StBusy      = 2'd0,
    StDone      = 2'd1,
    StBadParity = 2'd2
  } status_e;

  typedef struct packed {
    logic             push;
    logic             clear;
    logic             drop;
    logic [PtrW-1:0]  drop_cnt;
    logic [ByteW-1:0] data;
  } win_ctrl_t;

endpackage

`default_nettype wire

/* sv/mhfp_window.sv */
// twelve byte circular header window with push, clear and front drop
// depends on mhfp_pkg
`default_nettype none

module mhfp_window (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire mhfp_pkg::win_ctrl_t       ctrl_i,
  input  wire logic [mhfp_pkg::PtrW-1:0] rd_pos_i,
  output logic [mhfp_pkg::ByteW-1:0]     rd_data_o,
  output logic [mhfp_pkg::PtrW-1:0]      count_o
);

  localparam logic [mhfp_pkg::PtrW-1:0] Depth = mhfp_pkg::PtrW'(mhfp_pkg::WinDepth);

  logic [mhfp_pkg::ByteW-1:0] mem_q [mhfp_pkg::WinDepth];
  logic [mhfp_pkg::PtrW-1:0]  head_q, tail_q, count_q;
  logic [mhfp_pkg::PtrW-1:0]  rd_addr;

  function automatic logic [mhfp_pkg::PtrW-1:0] wrap_add(
    input logic [mhfp_pkg::PtrW-1:0] a,
    input logic [mhfp_pkg::PtrW-1:0] b
  );
    logic [mhfp_pkg::PtrW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, Depth}) begin
      s = s - {1'b0, Depth};
    end
    return s[mhfp_pkg::PtrW-1:0];
  endfunction

  assign rd_addr   = wrap_add(tail_q, rd_pos_i);
  assign rd_data_o = mem_q[rd_addr];
  assign count_o   = count_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[head_q] <= ctrl_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (ctrl_i.clear) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (ctrl_i.drop) begin
      tail_q  <= wrap_add(tail_q, ctrl_i.drop_cnt);
      count_q <= count_q - ctrl_i.drop_cnt;
    end else if (ctrl_i.push) begin
      head_q <= wrap_add(head_q, mhfp_pkg::PtrW'(1));
      if (count_q >= Depth) begin
        tail_q <= wrap_add(tail_q, mhfp_pkg::PtrW'(1));
      end else begin
        count_q <= count_q + mhfp_pkg::PtrW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/magic_header_frame_parser.sv */
// top level of the magic header frame parser: sequencer, header scan and output register
// depends on mhfp_pkg and mhfp_window
//
// usage
// - s_axis carries one received byte per word; m_axis returns exactly one result word
//   for every byte taken
// - a byte taken in payload mode, or in header mode while the window is not yet full,
//   gives its result through the done step and the output register
// - a byte that fills the header window starts a scan that reads the twelve window
//   bytes one per cycle through a single read port and one 8-bit adder, then a
//   decision step; its result then goes through the done step and the output register
// - s_axis_tready is high only while the sequencer is idle, so one byte is in work
//   at a time; a new byte is taken only after the last result is registered
// - the result waits in the output register while m_axis_tready is low; the
//   sequencer holds in its final step until that register is free
// - reset empties the window, selects header mode and clears the latched header
//   fields and the payload count
`default_nettype none

module magic_header_frame_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // rx_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[1:0], payload_valid[2], payload_byte[10:3], payload_index[26:11],
  // payload_length[42:27], reset_value[58:43], sequence_number[74:59],
  // op_code[90:75], header_parity[98:91], zero fill[103:99]
  output logic [103:0]      m_axis_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam int unsigned W = mhfp_pkg::WinDepth;
  localparam logic [mhfp_pkg::PtrW-1:0] LastPos = mhfp_pkg::PtrW'(W - 1);
  localparam logic [mhfp_pkg::PtrW-1:0] ParPos  = mhfp_pkg::PtrW'(3);

  logic [1:0]                  state_q;
  logic [mhfp_pkg::PtrW-1:0]   idx_q;
  logic [mhfp_pkg::ByteW-1:0]  sum_q, par_q;
  logic [63:0]                 fld_q;
  logic [W-1:0]                ma_q, mb_q, mc_q;
  logic                        in_payload_q;
  logic [15:0]                 pay_cnt_q, pay_cnt_d;
  logic [15:0]                 hdr_len_q, hdr_rst_q, hdr_seq_q, hdr_op_q;
  logic [7:0]                  hdr_par_q;
  mhfp_pkg::status_e           res_status_q;
  logic                        res_pvalid_q;
  logic [7:0]                  res_pbyte_q;
  logic [15:0]                 res_pindex_q;
  logic                        m_valid_q;
  logic [103:0]                m_data_q;

  mhfp_pkg::win_ctrl_t         win_ctrl;
  logic [mhfp_pkg::PtrW-1:0]   win_count;
  logic [mhfp_pkg::ByteW-1:0]  rd_byte;
  logic                        accept, out_free;
  logic                        magic_ok, parity_ok;
  logic [W+1:0]                mb_ext, mc_ext;
  logic [W-1:0]                cand;
  logic [mhfp_pkg::PtrW-1:0]   drop_k;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign pay_cnt_d     = pay_cnt_q + 16'd1;

  assign magic_ok  = ma_q[0] && mb_q[1] && mc_q[2];
  assign parity_ok = (par_q == ~sum_q);
  assign mb_ext    = {2'b00, mb_q};
  assign mc_ext    = {2'b00, mc_q};

  // first front offset whose remaining prefix matches the magic start
  always_comb begin
    cand   = '0;
    drop_k = mhfp_pkg::PtrW'(W);
    for (int k = 1; k < W; k++) begin
      cand[k] = ma_q[k] && ((k + 1 >= W) || mb_ext[k+1]) && ((k + 2 >= W) || mc_ext[k+2]);
    end
    for (int k = W - 1; k >= 1; k--) begin
      if (cand[k]) begin
        drop_k = mhfp_pkg::PtrW'(k);
      end
    end
  end

  always_comb begin
    win_ctrl          = '0;
    win_ctrl.data     = s_axis_tdata;
    win_ctrl.push     = accept && !in_payload_q;
    win_ctrl.drop_cnt = drop_k;
    if (state_q == S_EVAL) begin
      win_ctrl.clear = magic_ok && parity_ok;
      win_ctrl.drop  = !(magic_ok && parity_ok);
    end
  end

  mhfp_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (win_ctrl),
    .rd_pos_i  (idx_q),
    .rd_data_o (rd_byte),
    .count_o   (win_count)
  );

  // scan datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sum_q <= mhfp_pkg::ParitySeed;
    end else if (state_q == S_SCAN) begin
      ma_q <= {rd_byte == mhfp_pkg::MagicA, ma_q[W-1:1]};
      mb_q <= {rd_byte == mhfp_pkg::MagicB, mb_q[W-1:1]};
      mc_q <= {rd_byte == mhfp_pkg::MagicC, mc_q[W-1:1]};
      if (idx_q == ParPos) begin
        par_q <= rd_byte;
      end
      if (idx_q > ParPos) begin
        fld_q <= {rd_byte, fld_q[63:8]};
        sum_q <= sum_q + rd_byte;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      m_data_q <= {5'b0, hdr_par_q, hdr_op_q, hdr_seq_q, hdr_rst_q, hdr_len_q,
                   res_pindex_q, res_pbyte_q, res_pvalid_q, res_status_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      in_payload_q <= 1'b0;
      pay_cnt_q    <= '0;
      hdr_len_q    <= '0;
      hdr_rst_q    <= '0;
      hdr_seq_q    <= '0;
      hdr_op_q     <= '0;
      hdr_par_q    <= '0;
      res_status_q <= mhfp_pkg::StBusy;
      res_pvalid_q <= 1'b0;
      res_pbyte_q  <= '0;
      res_pindex_q <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          if (accept) begin
            if (in_payload_q) begin
              res_pvalid_q <= 1'b1;
              res_pbyte_q  <= s_axis_tdata;
              res_pindex_q <= pay_cnt_q;
              pay_cnt_q    <= pay_cnt_d;
              if (pay_cnt_d == hdr_len_q) begin
                in_payload_q <= 1'b0;
                res_status_q <= mhfp_pkg::StDone;
              end else begin
                res_status_q <= mhfp_pkg::StBusy;
              end
              state_q <= S_DONE;
            end else begin
              res_status_q <= mhfp_pkg::StBusy;
              res_pvalid_q <= 1'b0;
              res_pbyte_q  <= '0;
              res_pindex_q <= '0;
              state_q      <= (win_count >= LastPos) ? S_SCAN : S_DONE;
            end
          end
        end
        S_SCAN: begin
          idx_q <= idx_q + mhfp_pkg::PtrW'(1);
          if (idx_q == LastPos) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (magic_ok) begin
            hdr_len_q <= fld_q[15:0];
            hdr_rst_q <= fld_q[31:16];
            hdr_seq_q <= fld_q[47:32];
            hdr_op_q  <= fld_q[63:48];
            hdr_par_q <= par_q;
          end
          if (magic_ok && parity_ok) begin
            pay_cnt_q <= '0;
            if (fld_q[15:0] == 16'd0) begin
              res_status_q <= mhfp_pkg::StDone;
            end else begin
              in_payload_q <= 1'b1;
            end
          end else if (magic_ok) begin
            res_status_q <= mhfp_pkg::StBadParity;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_win_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_count <= mhfp_pkg::PtrW'(W))
    else $error("window count beyond depth");

  a_good_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && magic_ok && parity_ok) |=> (win_count == '0))
    else $error("good header did not empty the window");

  a_pay_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (hdr_len_q != 16'd0))
    else $error("payload mode with zero length");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[2]) |-> (m_data_q[26:11] < m_data_q[42:27]))
    else $error("payload index not below length");

endmodule

`default_nettype wire
